@@ design/utf16le_to_utf8_transcoder_top_assert.svh @@
// Assertion macros used by the transcoder back end.
// No dependencies; compiled out when SYNTH is defined.
`ifndef UTF16LE_TO_UTF8_TRANSCODER_TOP_ASSERT_SVH
`define UTF16LE_TO_UTF8_TRANSCODER_TOP_ASSERT_SVH
`ifndef SYNTH
// Clocked check, masked while reset is asserted
`define U16U8_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define U16U8_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U16U8_ASSERT(lbl, clk, rst_n, prop, msg)
`define U16U8_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ design/u16u8_pkg.sv @@
// Types, constants and the BMP encoder shared by the transcoder modules.
// No dependencies.
package u16u8_pkg;

    localparam int MAX_BYTES = 6;
    localparam int CNT_W     = 3;

    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
    localparam logic [20:0] CP_BASE     = 21'h10000;
    localparam logic [15:0] LIM_ONE     = 16'h0080;
    localparam logic [15:0] LIM_TWO     = 16'h0800;
    localparam logic [7:0]  LEAD_FOUR   = 8'hF0;
    localparam logic [7:0]  LEAD_THREE  = 8'hE0;
    localparam logic [7:0]  LEAD_TWO    = 8'hC0;
    localparam logic [7:0]  CONT_MARK   = 8'h80;

    // encoded BMP unit: up to three bytes, b[0] goes out first
    typedef struct packed {
        logic [2:0][7:0] b;
        logic [1:0]      len;
    } t_seg;

    // one queued job: all bytes caused by one input beat
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } t_job;

    function automatic t_seg enc_bmp(input logic [15:0] u);
        t_seg s;
        s = '0;
        if (u < LIM_ONE) begin
            s.b[0] = u[7:0];
            s.len  = 2'd1;
        end else if (u < LIM_TWO) begin
            s.b[0] = LEAD_TWO | {3'b000, u[10:6]};
            s.b[1] = CONT_MARK | {2'b00, u[5:0]};
            s.len  = 2'd2;
        end else begin
            s.b[0] = LEAD_THREE | {4'b0000, u[15:12]};
            s.b[1] = CONT_MARK | {2'b00, u[11:6]};
            s.b[2] = CONT_MARK | {2'b00, u[5:0]};
            s.len  = 2'd3;
        end
        return s;
    endfunction

endpackage

@@ design/u16u8_in_if.sv @@
// Input stream interface: one UTF-16 code unit per beat.
// No dependencies.
interface u16u8_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_unit;

    modport source (output valid, output code_unit, output last_unit, input ready);
    modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

@@ design/u16u8_out_if.sv @@
// Output stream interface: one UTF-8 byte per beat.
// No dependencies.
interface u16u8_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

@@ design/u16u8_front.sv @@
// Front end: accepts code units, tracks the held high surrogate and
// builds the byte list of each beat. Depends on u16u8_pkg, u16u8_in_if.
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    u16u8_in_if.sink    i_in,
    output logic        o_push_valid,
    input  logic        i_push_ready,
    output t_job        o_job
);

    logic       r_pend;
    logic [9:0] r_hi;
    logic       n_pend;
    logic [9:0] n_hi;

    logic        fire;
    logic        is_high;
    logic        is_low;
    logic        hold;
    t_seg        seg_u;
    t_seg        seg_p;
    logic [20:0] cp;
    t_job        job;

    assign fire       = i_in.valid && i_push_ready;
    assign i_in.ready = i_push_ready;

    // classify and encode
    always_comb begin
        is_high = i_in.code_unit inside {[SURR_HI_MIN:SURR_HI_MAX]};
        is_low  = i_in.code_unit inside {[SURR_LO_MIN:SURR_LO_MAX]};
        hold    = is_high && !i_in.last_unit;
        seg_u   = enc_bmp(i_in.code_unit);
        seg_p   = enc_bmp(SURR_HI_MIN | {6'b000000, r_hi});
        cp      = CP_BASE + {1'b0, r_hi, 10'b0} + {11'b0, i_in.code_unit[9:0]};
        job     = '0;
        n_pend  = r_pend;
        n_hi    = r_hi;
        if (r_pend && is_low) begin
            // surrogate pair: four bytes
            job.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
            job.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
            job.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
            job.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
            job.count    = CNT_W'(4);
            n_pend       = 1'b0;
            n_hi         = '0;
        end else if (r_pend) begin
            // flush held surrogate (always 3 bytes), then the new unit unless it is held
            job.bytes[0] = seg_p.b[0];
            job.bytes[1] = seg_p.b[1];
            job.bytes[2] = seg_p.b[2];
            if (hold) begin
                job.count = CNT_W'(3);
                n_hi      = i_in.code_unit[9:0];
            end else begin
                job.bytes[3] = seg_u.b[0];
                job.bytes[4] = seg_u.b[1];
                job.bytes[5] = seg_u.b[2];
                job.count    = CNT_W'(3) + CNT_W'(seg_u.len);
                n_pend       = 1'b0;
                n_hi         = '0;
            end
        end else if (hold) begin
            n_pend = 1'b1;
            n_hi   = i_in.code_unit[9:0];
        end else begin
            job.bytes[0] = seg_u.b[0];
            job.bytes[1] = seg_u.b[1];
            job.bytes[2] = seg_u.b[2];
            job.count    = CNT_W'(seg_u.len);
        end
    end

    // held surrogate state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_hi   <= '0;
        end else if (fire) begin
            r_pend <= n_pend;
            r_hi   <= n_hi;
        end
    end

    // beats that cause no byte are not queued
    assign o_push_valid = i_in.valid && (job.count != '0);
    assign o_job        = job;

endmodule

@@ design/u16u8_queue.sv @@
// Two-entry job queue between front and back end.
// Depends on u16u8_pkg.
module u16u8_queue
    import u16u8_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_job,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic push;
    logic pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_job        = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ design/u16u8_back.sv @@
// Back end: serializes the head job one byte per beat into an output register.
// Depends on u16u8_pkg, u16u8_out_if, the assertion header.
`include "utf16le_to_utf8_transcoder_top_assert.svh"
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pop_valid,
    output logic        o_pop_ready,
    input  t_job        i_job,
    u16u8_out_if.source o_out
);

    logic [CNT_W-1:0] r_idx;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_last;

    logic load;
    logic at_end;

    assign load        = !r_valid || o_out.ready;
    assign at_end      = (r_idx == i_job.count - CNT_W'(1));
    assign o_pop_ready = load && at_end;

    // byte index within head job, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_pop_valid;
            if (i_pop_valid) begin
                r_idx <= at_end ? '0 : r_idx + CNT_W'(1);
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load && i_pop_valid) begin
            r_byte <= i_job.bytes[r_idx];
            r_last <= at_end;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.out_byte  = r_byte;
    assign o_out.last_byte = r_last;

    `U16U8_ASSERT(a_head_nonempty, i_clk, i_rst_n, i_pop_valid |-> (i_job.count != '0), "empty job queued")
    `U16U8_ASSERT(a_idx_range, i_clk, i_rst_n, i_pop_valid |-> (r_idx < i_job.count), "byte index past job end")
    `U16U8_ASSERT_ALWAYS(a_mid_job_head, i_clk, (i_rst_n && r_idx != '0) |-> i_pop_valid, "job lost mid-serialization")

endmodule

@@ design/utf16le_to_utf8_transcoder_top.sv @@
// Top level of the UTF-16LE to UTF-8 transcoder.
// Depends on u16u8_pkg, both stream interfaces, front, queue and back modules.
//
//  channel  dir  payload                      beat
//  i_in     in   code_unit[15:0], last_unit   one UTF-16 code unit
//  o_out    out  out_byte[7:0], last_byte     one UTF-8 byte
//
// One output byte per cycle from the back end's serializer while o_out.ready holds;
// an input beat causes 0 to 6 bytes and is accepted while the queue has room.
// The first byte of a beat passes the queue write, then the output register,
// before it is valid.
// A two-entry job queue lets input be taken while output is stalled.
// Synchronous active-low reset clears the held surrogate, queue and output.
module utf16le_to_utf8_transcoder_top
    import u16u8_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    u16u8_in_if.sink    i_in,
    u16u8_out_if.source o_out
);

    logic push_valid;
    logic push_ready;
    t_job push_job;
    logic pop_valid;
    logic pop_ready;
    t_job pop_job;

    u16u8_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_job        (push_job)
    );

    u16u8_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_job        (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_job        (pop_job)
    );

    u16u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_job       (pop_job),
        .o_out       (o_out)
    );

endmodule
